FILE: rtl/core/imfp_pkg.sv
`default_nettype none

package imfp_pkg;

   // Field kinds reported with every byte.
   localparam logic [2:0] KIND_NAME    = 3'd0;
   localparam logic [2:0] KIND_USER    = 3'd1;
   localparam logic [2:0] KIND_HOST    = 3'd2;
   localparam logic [2:0] KIND_COMMAND = 3'd3;
   localparam logic [2:0] KIND_PARAM   = 3'd4;
   localparam logic [2:0] KIND_SKIP    = 3'd5;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] field_kind;
      logic [3:0] param_index;
      logic [8:0] char_index;
      logic [7:0] out_byte;
      logic       is_trailing;
      logic       overflow;
      logic       message_end;
      logic [4:0] param_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/core/imfp_chan_if.sv
`default_nettype none

interface imfp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/imfp_tagger.sv
`default_nettype none

module imfp_tagger
   import imfp_pkg::*;
#(
   parameter int MAX_PARAMS    = 16,
   parameter int MAX_FIELD_LEN = 512
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire req_payload_type req,
   output rsp_payload_type      rsp
);

   localparam int PCW = $clog2(MAX_PARAMS + 1);
   localparam int CCW = $clog2(MAX_FIELD_LEN + 1);

   typedef enum logic [3:0] {
      PH_START,
      PH_NAME,
      PH_USER,
      PH_HOST,
      PH_PSKIP,
      PH_CMD,
      PH_PSPACE,
      PH_PARAM,
      PH_TRAIL
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [PCW-1:0] param_ff, param_in;
   logic [CCW-1:0] char_ff, char_in;
   logic           has_chars_ff, has_chars_in;
   logic           dropped_ff, dropped_in;

   logic [PCW-1:0] param_v;
   logic [CCW-1:0] char_v;
   logic           has_chars_v;
   logic           dropped_v;
   logic           clear_char;
   logic           start_param;
   logic           do_field;
   logic           do_param;
   logic           trailing;
   logic [2:0]     kind_v;
   logic [2:0]     field_kind_v;
   logic [PCW-1:0] count_v;
   logic [PCW-1:0] pidx_v;
   logic [PCW+3:0] pidx_ext;
   logic [PCW+4:0] count_ext;
   logic [CCW+8:0] cidx_ext;
   logic [8:0]     cidx_v;
   logic           ovf_v;
   logic [7:0]     b;

   assign b = req.data_byte;

   always_comb begin
      phase_in     = phase_ff;
      clear_char   = 1'b0;
      start_param  = 1'b0;
      do_field     = 1'b0;
      do_param     = 1'b0;
      trailing     = 1'b0;
      field_kind_v = KIND_SKIP;
      case (phase_ff)
         PH_NAME: begin
            if (b == CHAR_BANG) begin
               clear_char = 1'b1;
               phase_in   = PH_USER;
            end else if (b == CHAR_AT) begin
               clear_char = 1'b1;
               phase_in   = PH_HOST;
            end else if (b == CHAR_SPACE) begin
               phase_in = PH_PSKIP;
            end else begin
               do_field     = 1'b1;
               field_kind_v = KIND_NAME;
            end
         end
         PH_USER: begin
            if (b == CHAR_AT) begin
               clear_char = 1'b1;
               phase_in   = PH_HOST;
            end else if (b == CHAR_SPACE) begin
               phase_in = PH_PSKIP;
            end else begin
               do_field     = 1'b1;
               field_kind_v = KIND_USER;
            end
         end
         PH_HOST: begin
            if (b == CHAR_SPACE) begin
               phase_in = PH_PSKIP;
            end else begin
               do_field     = 1'b1;
               field_kind_v = KIND_HOST;
            end
         end
         PH_PSKIP: begin
            if (b != CHAR_SPACE) begin
               clear_char   = 1'b1;
               phase_in     = PH_CMD;
               do_field     = 1'b1;
               field_kind_v = KIND_COMMAND;
            end
         end
         PH_CMD: begin
            if (b == CHAR_SPACE) begin
               phase_in = PH_PSPACE;
            end else begin
               do_field     = 1'b1;
               field_kind_v = KIND_COMMAND;
            end
         end
         PH_PSPACE: begin
            if (b == CHAR_COLON) begin
               start_param = 1'b1;
               phase_in    = PH_TRAIL;
            end else if (b != CHAR_SPACE) begin
               start_param = 1'b1;
               phase_in    = PH_PARAM;
               do_param    = 1'b1;
            end
         end
         PH_PARAM: begin
            if (b == CHAR_SPACE) begin
               phase_in = PH_PSPACE;
            end else begin
               do_param = 1'b1;
            end
         end
         PH_TRAIL: begin
            do_param = 1'b1;
            trailing = 1'b1;
         end
         default: begin
            // Start of message: an optional prefix, a bare space, or the command.
            clear_char = 1'b1;
            if (b == CHAR_COLON) begin
               phase_in = PH_NAME;
            end else if (b == CHAR_SPACE) begin
               phase_in = PH_PSPACE;
            end else begin
               phase_in     = PH_CMD;
               do_field     = 1'b1;
               field_kind_v = KIND_COMMAND;
            end
         end
      endcase
   end

   always_comb begin
      param_v     = param_ff;
      char_v      = char_ff;
      has_chars_v = has_chars_ff;
      dropped_v   = dropped_ff;
      kind_v      = field_kind_v;
      pidx_v      = '0;
      cidx_ext    = '0;
      ovf_v       = 1'b0;

      if (clear_char) begin
         char_v = '0;
      end
      if (start_param) begin
         char_v      = '0;
         has_chars_v = 1'b0;
         if (param_ff < PCW'(MAX_PARAMS)) begin
            param_v   = param_ff + PCW'(1);
            dropped_v = 1'b0;
         end else begin
            dropped_v = 1'b1;
         end
      end

      if (do_param) begin
         kind_v = KIND_PARAM;
         if (dropped_v) begin
            ovf_v = 1'b1;
         end else begin
            pidx_v = param_v - PCW'(1);
         end
      end

      // A byte of a dropped parameter is neither counted nor stored.
      if (do_field || (do_param && !dropped_v)) begin
         if (char_v < CCW'(MAX_FIELD_LEN)) begin
            cidx_ext = {9'd0, char_v};
            char_v   = char_v + CCW'(1);
            if (do_param) begin
               has_chars_v = 1'b1;
            end
         end else begin
            ovf_v = 1'b1;
         end
      end

      count_v = '0;
      if (req.last_byte) begin
         count_v = param_v;
         if (phase_in == PH_TRAIL && !has_chars_v && !dropped_v && param_v != '0) begin
            count_v = param_v - PCW'(1);
         end
      end
   end

   assign pidx_ext  = {4'd0, pidx_v};
   assign count_ext = {5'd0, count_v};
   assign cidx_v    = cidx_ext[8:0];

   always_comb begin
      rsp.field_kind  = kind_v;
      rsp.param_index = pidx_ext[3:0];
      rsp.char_index  = cidx_v;
      rsp.out_byte    = b;
      rsp.is_trailing = trailing;
      rsp.overflow    = ovf_v;
      rsp.message_end = req.last_byte;
      rsp.param_count = count_ext[4:0];
   end

   // Next state; the last byte of a message returns everything to reset.
   always_comb begin
      param_in     = param_v;
      char_in      = char_v;
      has_chars_in = has_chars_v;
      dropped_in   = dropped_v;
      if (req.last_byte) begin
         param_in     = '0;
         char_in      = '0;
         has_chars_in = 1'b0;
         dropped_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         param_ff     <= '0;
         char_ff      <= '0;
         has_chars_ff <= 1'b0;
         dropped_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff     <= req.last_byte ? PH_START : phase_in;
         param_ff     <= param_in;
         char_ff      <= char_in;
         has_chars_ff <= has_chars_in;
         dropped_ff   <= dropped_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/irc_message_field_parser.sv
// Channel   Direction  Payload                         Moves
// req_chan  in         data_byte, last_byte            one message byte per request
// rsp_chan  out        field_kind .. param_count       one tag per request
//
// One request is accepted per cycle while req_chan.ready is high; its tag is registered.
// The per-byte state update is a single pass of logic from the tagger's state registers.
// A result register plus a skid register sit on the output, so a request is still
// accepted while the previous result waits; req_chan.ready drops only when both hold.
// Synchronous reset returns the parser to the start of a message and empties the output.
`default_nettype none

module irc_message_field_parser
   import imfp_pkg::*;
#(
   parameter int MAX_PARAMS    = 16,
   parameter int MAX_FIELD_LEN = 512
) (
   input wire logic clock,
   input wire logic reset,
   imfp_chan_if.sink   req_chan,
   imfp_chan_if.source rsp_chan
);

   rsp_payload_type tag;
   logic            accept;
   logic            take;

   rsp_payload_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type skid_ff, skid_in;
   logic            skid_valid_ff, skid_valid_in;

   imfp_tagger #(
      .MAX_PARAMS    (MAX_PARAMS),
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_tagger (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .req     (req_chan.payload),
      .rsp     (tag)
   );

   assign req_chan.ready   = !skid_valid_ff;
   assign accept           = req_chan.valid && !skid_valid_ff;
   assign take             = out_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = tag;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = tag;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
